// ===== rtl/bfbs_pkg.sv =====
// shared types and constants for the block framer with byte sum
package bfbs_pkg;

  localparam int unsigned BlockBytes = 512;
  localparam int unsigned PosW       = (BlockBytes > 2) ? $clog2(BlockBytes) : 1;
  localparam int unsigned MaxBytes   = 6;
  localparam int unsigned CntW       = $clog2(MaxBytes + 1);

  localparam logic [7:0] SohByte = 8'h01;
  localparam logic [7:0] StxByte = 8'h02;

  typedef enum logic [1:0] {
    KindData   = 2'd0,
    KindPad    = 2'd1,
    KindHeader = 2'd2,
    KindRaw    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [31:0] file_size;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       block_done;
  } out_t;

  typedef struct packed {
    logic                     valid;
    logic [CntW-1:0]          count;
    logic                     done;
    logic [MaxBytes-1:0][7:0] bytes;
  } frame_t;

endpackage

// ===== rtl/bfbs_framer.sv =====
// block state and frame builder: turns one request into a registered byte group
module bfbs_framer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bfbs_pkg::in_t     in_i,
  input  logic              take_i,
  output bfbs_pkg::frame_t  frame_o
);

  logic [15:0]               blk_q, blk_d;
  logic [bfbs_pkg::PosW-1:0] pos_q, pos_d;
  logic [31:0]               sum_q, sum_d, sum_new;
  logic [7:0]                byte_val;
  logic                      pos_last;
  logic                      accept;
  bfbs_pkg::frame_t          frame_q, frame_d;

  assign in_ready_o = !frame_q.valid || take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign frame_o    = frame_q;

  always_comb begin
    frame_d       = '0;
    frame_d.valid = 1'b1;
    blk_d         = blk_q;
    pos_d         = pos_q;
    sum_d         = sum_q;
    byte_val      = (in_i.kind == bfbs_pkg::KindData) ? in_i.data_byte : 8'h00;
    sum_new       = ((pos_q == '0) ? 32'h0 : sum_q) + {24'h0, byte_val};
    pos_last      = (pos_q == bfbs_pkg::PosW'(bfbs_pkg::BlockBytes - 1));
    case (in_i.kind)
      bfbs_pkg::KindHeader: begin
        frame_d.bytes[0] = bfbs_pkg::SohByte;
        frame_d.bytes[1] = bfbs_pkg::SohByte;
        frame_d.bytes[2] = in_i.file_size[31:24];
        frame_d.bytes[3] = in_i.file_size[23:16];
        frame_d.bytes[4] = in_i.file_size[15:8];
        frame_d.bytes[5] = in_i.file_size[7:0];
        frame_d.count    = bfbs_pkg::CntW'(6);
        blk_d            = '0;
        pos_d            = '0;
        sum_d            = '0;
      end
      bfbs_pkg::KindRaw: begin
        frame_d.bytes[0] = in_i.data_byte;
        frame_d.count    = bfbs_pkg::CntW'(1);
      end
      default: begin
        if (pos_last) begin
          frame_d.bytes[0] = byte_val;
          frame_d.bytes[1] = sum_new[31:24];
          frame_d.bytes[2] = sum_new[23:16];
          frame_d.bytes[3] = sum_new[15:8];
          frame_d.bytes[4] = sum_new[7:0];
          frame_d.count    = bfbs_pkg::CntW'(5);
          frame_d.done     = 1'b1;
          blk_d            = blk_q + 16'd1;
          pos_d            = '0;
          sum_d            = '0;
        end else begin
          if (pos_q == '0) begin
            frame_d.bytes[0] = bfbs_pkg::StxByte;
            frame_d.bytes[1] = blk_q[15:8];
            frame_d.bytes[2] = blk_q[7:0];
            frame_d.bytes[3] = byte_val;
            frame_d.count    = bfbs_pkg::CntW'(4);
          end else begin
            frame_d.bytes[0] = byte_val;
            frame_d.count    = bfbs_pkg::CntW'(1);
          end
          pos_d = pos_q + bfbs_pkg::PosW'(1);
          sum_d = sum_new;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q         <= '0;
      pos_q         <= '0;
      sum_q         <= '0;
      frame_q.valid <= 1'b0;
    end else begin
      if (accept) begin
        blk_q   <= blk_d;
        pos_q   <= pos_d;
        sum_q   <= sum_d;
        frame_q <= frame_d;
      end else if (take_i) begin
        frame_q.valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/bfbs_serializer.sv =====
// output stage: holds one byte group and hands it out one byte per cycle while out_ready_i is high
module bfbs_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfbs_pkg::frame_t  frame_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bfbs_pkg::out_t    out_o
);

  localparam int unsigned CntIdxW = bfbs_pkg::CntW;

  bfbs_pkg::frame_t      act_q;
  logic [CntIdxW-1:0]    idx_q;
  logic                  last;
  logic                  out_fire;

  assign last        = (idx_q == (act_q.count - bfbs_pkg::CntW'(1)));
  assign out_valid_o = act_q.valid;
  assign out_fire    = act_q.valid && out_ready_i;
  assign take_o      = frame_i.valid && (!act_q.valid || (out_ready_i && last));

  assign out_o.out_byte   = act_q.bytes[idx_q];
  assign out_o.run_last   = last;
  assign out_o.block_done = act_q.done && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q.valid <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (take_o) begin
        act_q <= frame_i;
        idx_q <= '0;
      end else if (out_fire) begin
        if (last) begin
          act_q.valid <= 1'b0;
          idx_q       <= '0;
        end else begin
          idx_q <= idx_q + CntIdxW'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/block_framer_with_byte_sum.sv =====
// top level of the block framer with byte sum
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_ready_o | bfbs_pkg::in_t  in_i
//   out     | output    | out_valid_o / out_ready_i | bfbs_pkg::out_t out_o
//
// each request becomes 1 to 6 output bytes, one per cycle while out_ready_i is high: 6 for a header,
// 1 for a raw byte, 1, 4 or 5 for data and pad bytes; the serializer sets the rate
// a request is framed in the cycle it is accepted and waits in a one-deep frame
// register while the previous group drains, so the next one follows without a gap
// reset clears the block number, position, running sum and both valid flags
// a stalled output holds its byte; the input stalls only while a frame waits
module block_framer_with_byte_sum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bfbs_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bfbs_pkg::out_t  out_o
);

  bfbs_pkg::frame_t frame;
  logic             take;

  bfbs_framer u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .take_i     (take),
    .frame_o    (frame)
  );

  bfbs_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.block_done |-> out_o.run_last)
    else $error("block_done without run_last");

  a_waiting_frame_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame.valid && !take |-> !in_ready_o)
    else $error("request accepted over a waiting frame");

  a_header_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_i.kind == bfbs_pkg::KindHeader)
    |=> frame.valid && (frame.count == bfbs_pkg::CntW'(6)) && !frame.done)
    else $error("header request did not frame six bytes");

  a_frame_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame.valid |-> (frame.count != '0))
    else $error("empty frame");

endmodule
